// File: rtl/stbs_pkg.sv
// Shared types and constants for the sorted table upper-bound search block.
// No dependencies; imported by every other file of the block except stbs_ram.
package stbs_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int VALUE_WIDTH         = 32;
   localparam int POSITION_WIDTH      = 10;
   localparam int ACTION_WIDTH        = 2;

   localparam logic [ACTION_WIDTH-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_APPEND = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_QUERY  = 2'd2;

   typedef struct packed {
      logic                      valid;
      logic                      found;
      logic [POSITION_WIDTH-1:0] position;
   } srch_rsp_type;

endpackage

// File: rtl/sorted_table_upper_bound_search.sv
// Sorted table with upper-bound search. Clear and append items are taken while no
// query is in progress; an append is written to the table RAM at the fill count,
// and an append to a full table is dropped. A query item with n filled entries
// needs at most ceil(log2(n+1)) probes, one per cycle, set by the single read port
// of the table RAM. Its result is registered, and the next item is taken in the
// cycle after the result is accepted. No new item is taken until the query result
// has been accepted. The table needs no clearing pass.
module sorted_table_upper_bound_search #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [stbs_pkg::ACTION_WIDTH-1:0]       req_action,
   input  logic signed [stbs_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_found,
   output logic [stbs_pkg::POSITION_WIDTH-1:0]     rsp_position
);
   import stbs_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   accept;
   logic                   wr_en;
   logic                   start;
   logic                   busy;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [VALUE_WIDTH-1:0] rd_data;
   srch_rsp_type           rsp;

   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;
   assign start     = accept && (req_action == ACT_QUERY);
   assign wr_en     = accept && (req_action == ACT_APPEND) &&
                      (count_ff < CNT_W'(TABLE_DEPTH));

   always_comb begin
      count_in = count_ff;
      if (accept && (req_action == ACT_CLEAR)) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   stbs_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   stbs_search #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .key       (req_value),
      .count     (count_ff),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .busy      (busy),
      .rsp       (rsp),
      .rsp_stall (rsp_stall)
   );

   assign rsp_valid    = rsp.valid;
   assign rsp_found    = rsp.found;
   assign rsp_position = rsp.position;

endmodule

// File: rtl/stbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/stbs_search.sv
// Binary search sequencer: one probe of the table RAM and one compare per cycle,
// and the result register. Depends on stbs_pkg.
module stbs_search #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [stbs_pkg::VALUE_WIDTH-1:0] key,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]       count,
   output logic                                   rd_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]         rd_addr,
   input  logic [stbs_pkg::VALUE_WIDTH-1:0]       rd_data,
   output logic                                   busy,
   output stbs_pkg::srch_rsp_type                 rsp,
   input  logic                                   rsp_stall
);
   import stbs_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = $clog2(TABLE_DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_PROBE,
      S_RESP
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          lo_ff, lo_in;
   logic [CNT_W-1:0]          hi_ff, hi_in;
   logic [IDX_W-1:0]          mid_ff, mid_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic                      found_ff, found_in;
   logic [POSITION_WIDTH-1:0] position_ff, position_in;

   logic                      greater;
   logic [CNT_W-1:0]          lo_next, hi_next;
   logic [CNT_W:0]            span_sum;
   logic [IDX_W-1:0]          mid_next;
   logic                      more;

   // Narrow the interval around the probe just read back
   always_comb begin
      greater  = $signed(rd_data) > key_ff;
      lo_next  = greater ? lo_ff : CNT_W'(mid_ff) + CNT_W'(1);
      hi_next  = greater ? CNT_W'(mid_ff) : hi_ff;
      span_sum = {1'b0, lo_next} + {1'b0, hi_next};
      mid_next = span_sum[IDX_W:1];
      more     = lo_next < hi_next;
   end

   always_comb begin
      state_in    = state_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      key_in      = key_ff;
      found_in    = found_ff;
      position_in = position_ff;
      rd_en       = 1'b0;
      rd_addr     = mid_next;
      case (state_ff)
         S_IDLE: begin
            rd_addr = IDX_W'(count >> 1);
            if (start) begin
               key_in = key;
               lo_in  = '0;
               hi_in  = count;
               mid_in = IDX_W'(count >> 1);
               if (count == '0) begin
                  found_in    = 1'b0;
                  position_in = '0;
                  state_in    = S_RESP;
               end else begin
                  rd_en    = 1'b1;
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            lo_in  = lo_next;
            hi_in  = hi_next;
            mid_in = mid_next;
            if (more) begin
               rd_en = 1'b1;
            end else begin
               found_in    = lo_next < count;
               position_in = (lo_next < count) ? POSITION_WIDTH'(lo_next) : '0;
               state_in    = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      key_ff      <= key_in;
      found_ff    <= found_in;
      position_ff <= position_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp.valid    = (state_ff == S_RESP);
   assign rsp.found    = found_ff;
   assign rsp.position = position_ff;

endmodule

// File: rtl/stbs_checker.sv
// Port-level checks for sorted_table_upper_bound_search, bound to the top level.
// Depends on stbs_pkg.
module stbs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [stbs_pkg::ACTION_WIDTH-1:0]   req_action,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_found,
   input logic [stbs_pkg::POSITION_WIDTH-1:0] rsp_position
);
   import stbs_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) && $stable(rsp_position))
      else $error("stalled result changed");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("position not zero on miss");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == ACT_QUERY |=> req_stall)
      else $error("query accepted but input not stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("item accepted while result pending");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown after reset");

endmodule

bind sorted_table_upper_bound_search stbs_checker u_stbs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_action   (req_action),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_found    (rsp_found),
   .rsp_position (rsp_position)
);

// File: bench/sorted_table_upper_bound_search_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for sorted_table_upper_bound_search: drives clear, append and query
// items, predicts each upper-bound answer from its own copy of the table. Needs stbs_pkg.
module sorted_table_upper_bound_search_tb;
   import stbs_pkg::*;

   localparam int TABLE_DEPTH = TABLE_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [ACTION_WIDTH-1:0] ACT_UNUSED = 2'd3;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic signed [VALUE_WIDTH-1:0] key;
      logic found;
      logic [POSITION_WIDTH-1:0] position;
   } search_answer_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [ACTION_WIDTH-1:0] req_action;
   logic signed [VALUE_WIDTH-1:0] req_value;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_found;
   logic [POSITION_WIDTH-1:0] rsp_position;

   logic signed [VALUE_WIDTH-1:0] model_entries [TABLE_DEPTH];
   int model_fill;
   search_answer_type pending_answers[$];

   int mismatch_count;
   int cycle_count;
   int hold_off_cycles;
   int stall_run;
   bit sender_idle_on;
   bit receiver_idle_on;

   sorted_table_upper_bound_search #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_found(rsp_found),
      .rsp_position(rsp_position)
   );

   always #5 clock = ~clock;

   // Mostly back to back, some short gaps, a few long ones.
   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!sender_idle_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int stall_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Upper bound over the filled part, same probe order as the block.
   function automatic search_answer_type predict_upper_bound(
      logic signed [VALUE_WIDTH-1:0] key);
      int lo;
      int hi;
      int mid;
      search_answer_type answer;
      lo = 0;
      hi = model_fill;
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (model_entries[mid] > key) hi = mid;
         else lo = mid + 1;
      end
      answer.key = key;
      answer.found = (lo < model_fill);
      answer.position = answer.found ? lo[POSITION_WIDTH-1:0] : '0;
      return answer;
   endfunction

   // Keys on, just below and just above stored entries hit the interesting branches.
   function automatic logic signed [VALUE_WIDTH-1:0] pick_key();
      int sel;
      int idx;
      sel = $urandom_range(0, 9);
      if (model_fill == 0 || sel < 2) return $urandom;
      idx = $urandom_range(0, model_fill - 1);
      case (sel)
         2, 3, 4, 5: return model_entries[idx];
         6, 7: return model_entries[idx] - 1;
         8: return model_entries[idx] + 1;
         default: return $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
      endcase
   endfunction

   task automatic send_item(input logic [ACTION_WIDTH-1:0] action,
                            input logic signed [VALUE_WIDTH-1:0] value, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (action)
         ACT_CLEAR: model_fill = 0;
         ACT_APPEND: begin
            if (model_fill < TABLE_DEPTH) begin
               model_entries[model_fill] = value;
               model_fill++;
            end
         end
         ACT_QUERY: begin
            pending_answers.insert(pending_answers.size(), predict_upper_bound(value));
         end
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      send_item(ACT_QUERY, VALUE_MIN, 0);
      send_item(ACT_QUERY, VALUE_MAX, 0);
      send_item(ACT_APPEND, VALUE_MIN, 0);
      send_item(ACT_APPEND, -1, 0);
      send_item(ACT_APPEND, 0, 0);
      send_item(ACT_APPEND, 5, 0);
      send_item(ACT_APPEND, 5, 0);
      send_item(ACT_APPEND, 5, 0);
      send_item(ACT_APPEND, VALUE_MAX, 0);
      send_item(ACT_QUERY, VALUE_MIN, 0);
      send_item(ACT_QUERY, -2, 0);
      send_item(ACT_QUERY, -1, 0);
      send_item(ACT_QUERY, 5, 0);
      send_item(ACT_QUERY, VALUE_MAX, 0);
      send_item(ACT_UNUSED, $urandom, 0);
      send_item(ACT_QUERY, 4, 0);
      send_item(ACT_CLEAR, $urandom, 0);
      send_item(ACT_QUERY, 0, 0);
      // out of order table: search still runs its fixed probes
      send_item(ACT_APPEND, 7, 0);
      send_item(ACT_APPEND, 3, 0);
      send_item(ACT_QUERY, 3, 0);
      send_item(ACT_QUERY, 7, 0);
      send_item(ACT_QUERY, 2, 0);
      wait_drained();
   endtask

   task automatic test_fill_to_capacity();
      longint running;
      int i;
      send_item(ACT_CLEAR, $urandom, next_gap());
      running = longint'(VALUE_MIN) + $urandom_range(0, 1000);
      for (i = 0; i < TABLE_DEPTH; i++) begin
         send_item(ACT_APPEND, running[VALUE_WIDTH-1:0], next_gap());
         if ($urandom_range(0, 7) == 0) send_item(ACT_QUERY, pick_key(), next_gap());
         if ($urandom_range(0, 15) != 0) running += $urandom_range(0, 4000000);
         if (running > VALUE_MAX) running = VALUE_MAX;
      end
      // table is full: these appends drop
      repeat (3) send_item(ACT_APPEND, $urandom, next_gap());
      repeat (20) send_item(ACT_QUERY, pick_key(), next_gap());
      wait_drained();
   endtask

   task automatic test_receiver_hold_off();
      hold_off_cycles = 150;
      repeat (6) send_item(ACT_QUERY, pick_key(), 0);
      wait_drained();
   endtask

   task automatic test_small_tables();
      longint running;
      int set_idx;
      int n;
      int j;
      bit scrambled;
      for (set_idx = 0; set_idx < 40; set_idx++) begin
         send_item(ACT_CLEAR, $urandom, next_gap());
         n = $urandom_range(0, 12);
         scrambled = ($urandom_range(0, 6) == 0);
         running = $signed(VALUE_WIDTH'($urandom));
         for (j = 0; j < n; j++) begin
            send_item(ACT_APPEND, scrambled ? VALUE_WIDTH'($urandom) : running[VALUE_WIDTH-1:0],
                      next_gap());
            if ($urandom_range(0, 19) == 0) send_item(ACT_UNUSED, $urandom, next_gap());
            if ($urandom_range(0, 3) != 0) running += $urandom_range(0, 1 << 24);
            if (running > VALUE_MAX) running = VALUE_MAX;
         end
         repeat ($urandom_range(2, 6)) send_item(ACT_QUERY, pick_key(), next_gap());
      end
      wait_drained();
   endtask

   task automatic test_full_rate();
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      repeat (40) begin
         if ($urandom_range(0, 2) == 0) send_item(ACT_APPEND, $urandom, 0);
         else send_item(ACT_QUERY, pick_key(), 0);
      end
      wait_drained();
      sender_idle_on = 1'b1;
      receiver_idle_on = 1'b1;
   endtask

   // Result side: a long hold-off when a test asks for one, else random stalls.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles--;
         end else begin
            if (stall_run == 0 && receiver_idle_on && $urandom_range(0, 99) < 20)
               stall_run = stall_length();
            rsp_stall <= (stall_run > 0);
            if (stall_run > 0) stall_run--;
         end
      end
   end

   always @(posedge clock) begin
      search_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected result found %0b position %0d",
                        $time, rsp_found, rsp_position);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_found !== want.found || rsp_position !== want.position) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"%0t: key %0d expected found %0b position %0d, ",
                            "got found %0b position %0d"},
                           $time, want.key, want.found, want.position, rsp_found, rsp_position);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_CLEAR;
      req_value = '0;
      rsp_stall = 1'b0;
      model_fill = 0;
      mismatch_count = 0;
      cycle_count = 0;
      hold_off_cycles = 0;
      stall_run = 0;
      sender_idle_on = 1'b1;
      receiver_idle_on = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_fill_to_capacity();
      test_receiver_hold_off();
      test_small_tables();
      test_full_rate();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
